FILE: sv/boau_pkg.sv
// ----------------------------------------------------------------------------
// boau_pkg
// shared types and constants for the banked operand access unit
// ----------------------------------------------------------------------------
package boau_pkg;

	localparam int REG_COUNT = 256;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_GUARD = 2'd1;
	localparam logic [1:0] ST_DEVRD = 2'd2;
	localparam logic [1:0] ST_DEVWR = 2'd3;

	localparam logic [2:0] DES_WORD = 3'd0;
	localparam logic [2:0] DES_T1   = 3'd1;
	localparam logic [2:0] DES_T2   = 3'd2;
	localparam logic [2:0] DES_T3   = 3'd3;
	localparam logic [2:0] DES_XI   = 3'd4;
	localparam logic [2:0] DES_I    = 3'd5;
	localparam logic [2:0] DES_W6   = 3'd6;
	localparam logic [2:0] DES_W7   = 3'd7;

	localparam logic [23:0] OOR_READ = 24'hFFFAAA;
	localparam int INT_BIT  = 23;
	localparam int HALF_BIT = 4;
	localparam int DEV_BIT  = 22;

	// action the back part performs for one item
	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,  // result fully known in front
		ACT_REGRD = 3'd1,
		ACT_REGWR = 3'd2,
		ACT_WIN   = 3'd3,  // windowed access, base lookup in back
		ACT_BASE  = 3'd4
	} act_t;

	typedef struct packed {
		act_t        act;
		logic        is_write;
		logic [23:0] eff_address;
		logic [5:0]  win;
		logic [17:0] off;
		logic        use_alt;
		logic [2:0]  designator;
		logic [23:0] write_value;
		logic        int_mode;
		logic        half;
		logic [23:0] imm_data;
		logic [1:0]  imm_status;
	} cmd_t;

	function automatic logic [23:0] sext8(input logic [7:0] x);
		return {{16{x[7]}}, x};
	endfunction

	function automatic logic [23:0] sext12(input logic [11:0] x);
		return {{12{x[11]}}, x};
	endfunction

	function automatic logic [23:0] extract_part(input logic [23:0] w,
			input logic [2:0] des, input logic half);
		case (des)
			DES_T1:  return sext8(w[23:16]);
			DES_T2:  return half ? sext12(w[23:12]) : sext8(w[15:8]);
			DES_T3:  return half ? sext12(w[11:0]) : sext8(w[7:0]);
			default: return w;
		endcase
	endfunction

	function automatic logic [23:0] merge_part(input logic [23:0] w,
			input logic [23:0] v, input logic [2:0] des, input logic half);
		case (des)
			DES_WORD, DES_W7: return v;
			DES_T1:  return {v[7:0], w[15:0]};
			DES_T2:  return half ? {v[11:0], w[11:0]} : {w[23:16], v[7:0], w[7:0]};
			DES_T3:  return half ? {w[23:12], v[11:0]} : {w[23:8], v[7:0]};
			default: return w;
		endcase
	endfunction

endpackage

FILE: sv/boau_ram.sv
// ----------------------------------------------------------------------------
// boau_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module boau_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		if (re) rdata <= mem_q[addr];
	end
endmodule

FILE: sv/boau_front.sv
// ----------------------------------------------------------------------------
// boau_front
// decodes one input beat into a command for the back part
// ----------------------------------------------------------------------------
module boau_front (
	input  logic [1:0]        opcode,
	input  logic [23:0]       eff_address,
	input  logic [2:0]        designator,
	input  logic [23:0]       write_value,
	input  logic [23:0]       status_word,
	output boau_pkg::cmd_t    cmd
);
	logic [5:0] win;

	always_comb begin
		win = (eff_address[23:18] != 6'd0) ? eff_address[23:18] : eff_address[17:12];
		cmd = '0;
		cmd.act         = boau_pkg::ACT_NONE;
		cmd.is_write    = (opcode == boau_pkg::OP_WRITE);
		cmd.eff_address = eff_address;
		cmd.win         = win;
		cmd.off         = (eff_address[23:18] != 6'd0) ? eff_address[17:0]
			: {6'd0, eff_address[11:0]};
		cmd.use_alt     = (win >= 6'd1) && (win <= 6'd7)
			&& status_word[4'd15 - 4'(win[2:0])];
		cmd.designator  = designator;
		cmd.write_value = write_value;
		cmd.int_mode    = status_word[boau_pkg::INT_BIT];
		cmd.half        = status_word[boau_pkg::HALF_BIT];
		cmd.imm_data    = '0;
		cmd.imm_status  = boau_pkg::ST_DONE;
		if (opcode == boau_pkg::OP_LOAD) begin
			cmd.act = boau_pkg::ACT_BASE;
		end else if (opcode == boau_pkg::OP_READ && (designator == boau_pkg::DES_XI
				|| designator == boau_pkg::DES_I)) begin
			cmd.imm_data = eff_address;
		end else if (opcode == boau_pkg::OP_NOP) begin
			cmd.act = boau_pkg::ACT_NONE;
		end else if (eff_address < 24'd256) begin
			if (opcode == boau_pkg::OP_READ) cmd.act = boau_pkg::ACT_REGRD;
			else if (!status_word[boau_pkg::INT_BIT] && eff_address[7])
				cmd.imm_status = boau_pkg::ST_GUARD;
			else cmd.act = boau_pkg::ACT_REGWR;
		end else begin
			cmd.act = boau_pkg::ACT_WIN;
		end
	end
endmodule

FILE: sv/boau_queue.sv
// ----------------------------------------------------------------------------
// boau_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module boau_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  boau_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output boau_pkg::cmd_t out_cmd
);
	boau_pkg::cmd_t ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd   = ent_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

FILE: sv/boau_back.sv
// ----------------------------------------------------------------------------
// boau_back
// executes commands: register file, base table, word memory
// ----------------------------------------------------------------------------
module boau_back #(
	parameter int MEM_WORDS = 262144
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  boau_pkg::cmd_t cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [23:0]    read_data,
	output logic [1:0]     access_status,
	output logic [5:0]     device_number,
	output logic [33:0]    device_address,
	output logic [23:0]    device_data
);
	localparam int MAW = $clog2(MEM_WORDS);
	localparam int RAW = $clog2(boau_pkg::REG_COUNT);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_BASE = 5'b00010,  // base table read under way
		S_MEM  = 5'b00100,  // word memory read under way
		S_REG  = 5'b01000,  // register file read under way
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	boau_pkg::cmd_t c_q;
	logic [MAW-1:0] phys_q;

	// clearing pass over register file and base table after reset
	logic [RAW:0]  clr_q;
	logic          clearing;

	logic          rf_we, rf_re, bt_we, bt_re, wm_we, wm_re;
	logic [RAW-1:0] rf_addr;
	logic [6:0]    bt_addr;
	logic [MAW-1:0] wm_addr;
	logic [23:0]   rf_wd, rf_rd, bt_wd, bt_rd, wm_wd, wm_rd;
	logic          take;
	logic [6:0]    bidx;
	logic [23:0]   rb;
	logic          is_dev;
	logic [39:0]   phys;
	logic          oor;

	boau_ram #(.WIDTH(24), .DEPTH(boau_pkg::REG_COUNT)) u_rf (.clk, .we(rf_we),
		.re(rf_re), .addr(rf_addr), .wdata(rf_wd), .rdata(rf_rd));
	boau_ram #(.WIDTH(24), .DEPTH(128)) u_bt (.clk, .we(bt_we), .re(bt_re),
		.addr(bt_addr), .wdata(bt_wd), .rdata(bt_rd));
	boau_ram #(.WIDTH(24), .DEPTH(MEM_WORDS)) u_wm (.clk, .we(wm_we), .re(wm_re),
		.addr(wm_addr), .wdata(wm_wd), .rdata(wm_rd));

	assign clearing = !clr_q[RAW];
	assign cmd_ready = (state_q == S_IDLE) && !clearing;
	assign take = cmd_valid && cmd_ready;
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		bidx = cmd.use_alt ? {1'b1, cmd.win} : {1'b0, cmd.win};
		rf_addr = clearing ? clr_q[RAW-1:0] : cmd.eff_address[RAW-1:0];
		rf_wd = clearing ? 24'd0 : cmd.write_value;
		rf_we = clearing || (take && cmd.act == boau_pkg::ACT_REGWR);
		rf_re = take && cmd.act == boau_pkg::ACT_REGRD;
		if (clearing) bt_addr = clr_q[6:0];
		else if (cmd.act == boau_pkg::ACT_BASE) bt_addr = cmd.eff_address[6:0];
		else bt_addr = bidx;
		bt_wd = clearing ? 24'd0 : cmd.write_value;
		bt_we = clearing || (take && cmd.act == boau_pkg::ACT_BASE);
		bt_re = take && cmd.act == boau_pkg::ACT_WIN;
		// base lookup result of the held command
		rb = bt_rd;
		is_dev = rb[boau_pkg::DEV_BIT] && (rb[5:0] != 6'd0);
		phys = ({18'd0, rb[21:0]} << 12) | {22'd0, c_q.off};
		oor = (phys >= 40'(MEM_WORDS));
		wm_addr = (state_q == S_MEM) ? phys_q : phys[MAW-1:0];
		wm_re = (state_q == S_BASE) && !is_dev && !oor;
		wm_we = (state_q == S_MEM) && c_q.is_write;
		wm_wd = boau_pkg::merge_part(wm_rd, c_q.write_value, c_q.designator, c_q.half);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clr_q <= '0;
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			unique case (state_q)
				S_IDLE: if (take) begin
					if (cmd.act == boau_pkg::ACT_WIN) state_q <= S_BASE;
					else if (cmd.act == boau_pkg::ACT_REGRD) state_q <= S_REG;
					else state_q <= S_OUT;
				end
				S_BASE: state_q <= (!is_dev && !oor) ? S_MEM : S_OUT;
				S_MEM:  state_q <= S_OUT;
				S_REG:  state_q <= S_OUT;
				S_OUT:  if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			c_q <= cmd;
			read_data <= cmd.imm_data;
			access_status <= cmd.imm_status;
			device_number <= '0;
			device_address <= '0;
			device_data <= '0;
		end
		if (state_q == S_BASE) begin
			phys_q <= phys[MAW-1:0];
			if (is_dev) begin
				device_number <= rb[5:0];
				device_address <= {rb[21:6], 18'd0} | {16'd0, c_q.off};
				access_status <= c_q.is_write ? boau_pkg::ST_DEVWR : boau_pkg::ST_DEVRD;
				device_data <= c_q.is_write ? c_q.write_value : 24'd0;
			end else if (oor) begin
				access_status <= c_q.int_mode ? boau_pkg::ST_DONE : boau_pkg::ST_GUARD;
				read_data <= c_q.is_write ? 24'd0 : boau_pkg::OOR_READ;
			end
		end
		if (state_q == S_MEM && !c_q.is_write)
			read_data <= boau_pkg::extract_part(wm_rd, c_q.designator, c_q.half);
		// register file read data is captured into read_data in S_REG
		if (state_q == S_REG)
			read_data <= rf_rd;
	end
endmodule

FILE: sv/banked_operand_access_unit.sv
// ----------------------------------------------------------------------------
// banked_operand_access_unit
// operand access unit: front decode, command queue, back execution
// ----------------------------------------------------------------------------
// sequencing: immediates, register writes and base loads go from S_IDLE to S_OUT;
//   register reads pass S_REG, device forwards and out-of-range pass S_BASE, and
//   word memory passes S_BASE then S_MEM (base read, memory read) before S_OUT
// flow: the back sequencer holds one command until its result beat is taken
// reset: arst_n clears the queue and the sequencer, then a clearing pass zeroes
//   register file and base table; word memory is undefined until written
module banked_operand_access_unit #(
	parameter int MEM_WORDS = 262144
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [23:0] eff_address,
	input  logic [2:0]  designator,
	input  logic [23:0] write_value,
	input  logic [23:0] status_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] read_data,
	output logic [1:0]  access_status,
	output logic [5:0]  device_number,
	output logic [33:0] device_address,
	output logic [23:0] device_data
);
	boau_pkg::cmd_t f_cmd, q_cmd;
	logic q_valid, q_ready;

	// front: classify the beat
	boau_front u_front (.opcode, .eff_address, .designator, .write_value,
		.status_word, .cmd(f_cmd));

	// queue lets the front keep taking beats while the back works, until it holds two
	boau_queue u_queue (.clk, .arst_n, .in_valid, .in_ready, .in_cmd(f_cmd),
		.out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd));

	boau_back #(.MEM_WORDS(MEM_WORDS)) u_back (.clk, .arst_n,
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.out_valid, .out_ready, .read_data, .access_status, .device_number,
		.device_address, .device_data);
endmodule

FILE: sv/boau_checker.sv
// ----------------------------------------------------------------------------
// boau_checker
// port-level checks on the operand access unit
// ----------------------------------------------------------------------------
module boau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  access_status,
	input logic [5:0]  device_number,
	input logic [23:0] read_data,
	input logic [23:0] device_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data))
		else $error("result beat dropped");
	a_dev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (access_status == boau_pkg::ST_DEVRD
		|| access_status == boau_pkg::ST_DEVWR) |-> device_number != 6'd0)
		else $error("device request without device");
	a_nodev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && access_status != boau_pkg::ST_DEVWR |-> device_data == 24'd0)
		else $error("device data outside device write");
	a_devrd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && access_status == boau_pkg::ST_DEVRD |-> read_data == 24'd0)
		else $error("read data on device read");
endmodule

bind banked_operand_access_unit boau_checker u_chk (.clk, .arst_n, .out_valid,
	.out_ready, .access_status, .device_number, .read_data, .device_data);
